// ===== design/mfd_pkg.sv =====
// ---------------------------------------------------------------------------
// mfd_pkg: MAC forwarding decision shared definitions
// Table geometry, field widths, ethertypes and result codes used by the
// channel interfaces, the decision core and the checker.
// ---------------------------------------------------------------------------
package mfd_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam int MAC_W    = 48;
   localparam int PORT_W   = 8;
   localparam int ETYPE_W  = 16;
   localparam int ACTION_W = 3;
   localparam int ENTRY_W  = PORT_W + MAC_W;

   localparam logic [CNT_W-1:0]   TABLE_COUNT = CNT_W'(TABLE_ENTRIES);
   localparam logic [MAC_W-1:0]   MAC_BCAST   = {MAC_W{1'b1}};
   localparam logic [ETYPE_W-1:0] ETH_IP      = 16'h0800;
   localparam logic [ETYPE_W-1:0] ETH_ARP     = 16'h0806;

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_ADD    = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_DROP   = 3'd0,
      ACT_FILTER = 3'd1,
      ACT_PORT   = 3'd2,
      ACT_ADDED  = 3'd3,
      ACT_FULL   = 3'd4
   } action_type;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [MAC_W-1:0]  mac;
   } entry_type;

endpackage

// ===== design/mfd_channel_if.sv =====
// ---------------------------------------------------------------------------
// mfd_channel_if: request and response channels
// Valid/ready channels carrying one request beat (packet header or table
// add) and one response beat (forwarding decision or add result).
// ---------------------------------------------------------------------------
interface mfd_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [mfd_pkg::MAC_W-1:0]   mac_addr;
   logic [mfd_pkg::MAC_W-1:0]   src_mac;
   logic [mfd_pkg::ETYPE_W-1:0] ether_type;
   logic [mfd_pkg::PORT_W-1:0]  port_in;

   modport source (output valid, op, mac_addr, src_mac, ether_type, port_in,
                   input ready);
   modport sink   (input valid, op, mac_addr, src_mac, ether_type, port_in,
                   output ready);
endinterface

interface mfd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mfd_pkg::ACTION_W-1:0] action;
   logic [mfd_pkg::PORT_W-1:0]   port_out;
   logic                         last;

   modport source (output valid, action, port_out, last, input ready);
   modport sink   (input valid, action, port_out, last, output ready);
endinterface

// ===== design/mfd_table_ram.sv =====
// ---------------------------------------------------------------------------
// mfd_table_ram: forwarding table memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mfd_table_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 56
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mac_forwarding_decision_core.sv =====
// ---------------------------------------------------------------------------
// mac_forwarding_decision_core: layer-2 forwarding decision engine
// Classifies packet headers against a MAC-to-port table and handles table
// adds, one request beat at a time.
// ---------------------------------------------------------------------------
// A request beat is taken only while the core is idle; the next one can be
// taken while the previous response still waits in the output register.
// Adds, drops and filter decisions are accepted in S_IDLE and decided in
// S_DECIDE; a broadcast ARP first sends its filter copy from S_DECIDE and
// then decides again. Unicast lookups and broadcasts from the default
// source walk the table RAM through its single read port, one slot per cycle
// from slot 0, and stop at the first hit or after the last filled slot.
// Slots fill in order, so a slot is valid exactly when its index is below
// fill_count and the RAM needs no clearing after reset. Response back-pressure
// holds a finished decision in S_DECIDE or S_SCAN until the output is free.
module mac_forwarding_decision_core (
   input logic       clock,
   input logic       reset,
   mfd_req_if.sink   req_bus,
   mfd_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN
   } state_type;

   state_type                        state_ff, state_in;
   logic                             item_op_ff, item_op_in;
   logic [mfd_pkg::MAC_W-1:0]        item_mac_ff, item_mac_in;
   logic [mfd_pkg::MAC_W-1:0]        item_src_ff, item_src_in;
   logic [mfd_pkg::ETYPE_W-1:0]      item_etype_ff, item_etype_in;
   logic [mfd_pkg::PORT_W-1:0]       item_port_ff, item_port_in;
   logic                             copy_done_ff, copy_done_in;
   logic                             any_slot_ff, any_slot_in;
   logic [mfd_pkg::CNT_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [mfd_pkg::CNT_W-1:0]        fill_count_ff, fill_count_in;
   logic [mfd_pkg::MAC_W-1:0]        default_mac_ff, default_mac_in;
   logic [mfd_pkg::PORT_W-1:0]       default_port_ff, default_port_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   mfd_pkg::action_type              rsp_action_ff, rsp_action_in;
   logic [mfd_pkg::PORT_W-1:0]       rsp_port_ff, rsp_port_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             push_ok;
   logic                             push;
   mfd_pkg::action_type              push_action;
   logic [mfd_pkg::PORT_W-1:0]       push_port;
   logic                             push_last;

   logic                             wr_en;
   logic                             rd_en;
   logic [mfd_pkg::IDX_W-1:0]        rd_addr;
   logic [mfd_pkg::ENTRY_W-1:0]      rd_word;
   mfd_pkg::entry_type               rd_entry;
   mfd_pkg::entry_type               wr_entry;
   logic [mfd_pkg::CNT_W-1:0]        scan_next;

   logic is_ip, is_arp, is_bcast, dst_default, src_default, table_full;
   logic table_empty, scan_hit;

   mfd_table_ram #(
      .DEPTH (mfd_pkg::TABLE_ENTRIES),
      .WIDTH (mfd_pkg::ENTRY_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_count_ff[mfd_pkg::IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = mfd_pkg::entry_type'(rd_word);
   assign wr_entry = '{port: item_port_ff, mac: item_mac_ff};

   assign is_ip       = (item_etype_ff == mfd_pkg::ETH_IP);
   assign is_arp      = (item_etype_ff == mfd_pkg::ETH_ARP);
   assign is_bcast    = (item_mac_ff == mfd_pkg::MAC_BCAST);
   assign dst_default = (item_mac_ff == default_mac_ff);
   assign src_default = (item_src_ff == default_mac_ff);
   assign table_full  = (fill_count_ff >= mfd_pkg::TABLE_COUNT);
   assign table_empty = (fill_count_ff == '0);
   assign scan_hit    = any_slot_ff || (rd_entry.mac == item_mac_ff);
   assign scan_next   = scan_idx_ff + mfd_pkg::CNT_W'(1);

   assign push_ok = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in        = state_ff;
      item_op_in      = item_op_ff;
      item_mac_in     = item_mac_ff;
      item_src_in     = item_src_ff;
      item_etype_in   = item_etype_ff;
      item_port_in    = item_port_ff;
      copy_done_in    = copy_done_ff;
      any_slot_in     = any_slot_ff;
      scan_idx_in     = scan_idx_ff;
      fill_count_in   = fill_count_ff;
      default_mac_in  = default_mac_ff;
      default_port_in = default_port_ff;
      push            = 1'b0;
      push_action     = mfd_pkg::ACT_DROP;
      push_port       = '0;
      push_last       = 1'b1;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      rd_addr         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               item_op_in    = req_bus.op;
               item_mac_in   = req_bus.mac_addr;
               item_src_in   = req_bus.src_mac;
               item_etype_in = req_bus.ether_type;
               item_port_in  = req_bus.port_in;
               copy_done_in  = 1'b0;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (item_op_ff == mfd_pkg::OP_ADD) begin
               if (push_ok) begin
                  push            = 1'b1;
                  push_action     = table_full ? mfd_pkg::ACT_FULL : mfd_pkg::ACT_ADDED;
                  wr_en           = !table_full;
                  fill_count_in   = table_full ? fill_count_ff
                                               : fill_count_ff + mfd_pkg::CNT_W'(1);
                  default_mac_in  = item_mac_ff;
                  default_port_in = item_port_ff;
                  state_in        = S_IDLE;
               end
            end else if (!is_ip && !is_arp) begin
               if (push_ok) begin
                  push     = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (dst_default) begin
               if (push_ok) begin
                  push        = 1'b1;
                  push_action = mfd_pkg::ACT_FILTER;
                  state_in    = S_IDLE;
               end
            end else if (is_bcast && is_arp && !copy_done_ff) begin
               if (push_ok) begin
                  push         = 1'b1;
                  push_action  = mfd_pkg::ACT_FILTER;
                  push_last    = 1'b0;
                  copy_done_in = 1'b1;
               end
            end else if (is_bcast && !src_default) begin
               if (push_ok) begin
                  push        = 1'b1;
                  push_action = mfd_pkg::ACT_FILTER;
                  state_in    = S_IDLE;
               end
            end else if (table_empty) begin
               if (push_ok) begin
                  push        = 1'b1;
                  push_action = (!is_bcast && src_default) ? mfd_pkg::ACT_PORT
                                                           : mfd_pkg::ACT_DROP;
                  push_port   = (!is_bcast && src_default) ? default_port_ff : '0;
                  state_in    = S_IDLE;
               end
            end else begin
               rd_en       = 1'b1;
               scan_idx_in = '0;
               any_slot_in = is_bcast;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               if (push_ok) begin
                  push        = 1'b1;
                  push_action = mfd_pkg::ACT_PORT;
                  push_port   = rd_entry.port;
                  state_in    = S_IDLE;
               end
            end else if (scan_next < fill_count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = scan_next[mfd_pkg::IDX_W-1:0];
               scan_idx_in = scan_next;
            end else if (push_ok) begin
               push        = 1'b1;
               push_action = src_default ? mfd_pkg::ACT_PORT : mfd_pkg::ACT_DROP;
               push_port   = src_default ? default_port_ff : '0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_action_in = rsp_action_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_last_in   = rsp_last_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = push_action;
         rsp_port_in   = push_port;
         rsp_last_in   = push_last;
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         copy_done_ff    <= 1'b0;
         fill_count_ff   <= '0;
         default_mac_ff  <= '0;
         default_port_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         copy_done_ff    <= copy_done_in;
         fill_count_ff   <= fill_count_in;
         default_mac_ff  <= default_mac_in;
         default_port_ff <= default_port_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      item_op_ff    <= item_op_in;
      item_mac_ff   <= item_mac_in;
      item_src_ff   <= item_src_in;
      item_etype_ff <= item_etype_in;
      item_port_ff  <= item_port_in;
      any_slot_ff   <= any_slot_in;
      scan_idx_ff   <= scan_idx_in;
      rsp_action_ff <= rsp_action_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_bus.ready    = (state_ff == S_IDLE);
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.action   = rsp_action_ff;
   assign rsp_bus.port_out = rsp_port_ff;
   assign rsp_bus.last     = rsp_last_ff;

endmodule

// ===== design/mfd_checker.sv =====
// ---------------------------------------------------------------------------
// mfd_checker: port-level checks for the forwarding decision core
// Watches the request and response channels of the top level only.
// ---------------------------------------------------------------------------
module mfd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mfd_pkg::ACTION_W-1:0] rsp_action,
   input logic [mfd_pkg::PORT_W-1:0]   rsp_port_out,
   input logic                         rsp_last
);

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat withdrawn while stalled");

   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a beat is still in work");

   a_port_only_on_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action != mfd_pkg::ACT_PORT) |-> (rsp_port_out == '0))
      else $error("port number on a beat that does not forward");

   a_copy_is_filter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_action == mfd_pkg::ACT_FILTER))
      else $error("non-final beat that is not a filter copy");

endmodule

bind mac_forwarding_decision_core mfd_checker u_mfd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_action   (rsp_bus.action),
   .rsp_port_out (rsp_bus.port_out),
   .rsp_last     (rsp_bus.last)
);
